>>> hw/rtl/qap_pkg.sv
// ----------------------------------------------------------------------------
// qap_pkg: shared types, constants and tables for the attitude propagator
// Holds the word formats, the controller states, the micro-op table for the
// shared multiplier, the CORDIC arctangent table and the output helpers.
// ----------------------------------------------------------------------------
package qap_pkg;

	// word formats
	localparam int QUAT_W            = 24;
	localparam int QFRAC             = QUAT_W - 2;
	localparam int RATE_W            = 16;
	localparam int BODY_W            = RATE_W + 1;
	localparam int ANGLE_W           = 16;
	localparam int DT_W              = 16;
	localparam int CFG_IDX_W         = 4;
	localparam int CFG_DATA_W        = 16;
	localparam int MA_W              = QUAT_W + 8;
	localparam int MB_W              = QUAT_W + 1;
	localparam int P_W               = MA_W + MB_W;
	localparam int ACC_W             = BODY_W + QUAT_W + 3;
	localparam int ANG_W             = QUAT_W + 6;
	localparam int SQ_W              = 2 * QFRAC + 2;
	localparam int X_W               = ANG_W + 12;
	localparam int Z_W               = 34;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int CNT_W             = 5;
	localparam int OP_W              = 5;

	localparam logic [DT_W-1:0]         DT_RESET = DT_W'(66);
	localparam logic signed [ANG_W-1:0] ONE_ANG  = ANG_W'(1) <<< QFRAC;
	localparam logic [QUAT_W-1:0]       ONE_QUAT = QUAT_W'(1) << QFRAC;
	localparam logic [SQ_W-1:0]         SQ_TOP   = SQ_W'(1) << (2 * QFRAC);
	localparam logic signed [Z_W-1:0]   HALF_PI  = Z_W'(64'd1686629713);

	// micro-op range of the shared multiplier
	localparam logic [OP_W-1:0] OP_ANG_FIRST = OP_W'(16);
	localparam logic [OP_W-1:0] OP_LAST      = OP_W'(26);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y        = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z        = CFG_IDX_W'(3);

	typedef struct packed {
		logic                     command;
		logic signed [RATE_W-1:0] rate_x;
		logic signed [RATE_W-1:0] rate_y;
		logic signed [RATE_W-1:0] rate_z;
		logic signed [QUAT_W-1:0] load_w;
		logic signed [QUAT_W-1:0] load_x;
		logic signed [QUAT_W-1:0] load_y;
		logic signed [QUAT_W-1:0] load_z;
	} qap_in_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0]  quat_w;
		logic signed [QUAT_W-1:0]  quat_x;
		logic signed [QUAT_W-1:0]  quat_y;
		logic signed [QUAT_W-1:0]  quat_z;
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] yaw_angle;
	} qap_out_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_A, ST_MUL_B, ST_SQRT_GO, ST_SQRT_WAIT,
		ST_CRD_GO, ST_CRD_WAIT, ST_FINISH
	} qap_state_t;

	typedef enum logic [1:0] {ANG_ROLL, ANG_PITCH, ANG_YAW} qap_ang_t;

	typedef enum logic [3:0] {
		A_RX, A_RY, A_RZ, A_Q0, A_Q1, A_Q2, A_Q3, A_S, A_SP
	} qap_asel_t;

	typedef enum logic [2:0] {B_Q0, B_Q1, B_Q2, B_Q3, B_DT, B_SP} qap_bsel_t;

	typedef enum logic [2:0] {K_NOP, K_ACC, K_UPD, K_ANG, K_SQ} qap_kind_t;

	typedef struct packed {
		qap_asel_t asel;
		qap_bsel_t bsel;
		qap_kind_t kind;
		logic [2:0] dst;
		logic       neg;
	} qap_mop_t;

	// controller -> datapath
	typedef struct packed {
		logic            accept;
		logic            op_a;
		logic            op_b;
		logic [OP_W-1:0] op_idx;
		logic            sqrt_go;
		logic            cordic_go;
		qap_ang_t        ang_sel;
		logic            publish;
	} qap_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
		logic out_free;
	} qap_sts_t;

	// micro-op table: rate products, step updates, angle products, sp squared
	function automatic qap_mop_t qap_mop(input logic [OP_W-1:0] idx);
		qap_mop_t m;
		m = '{A_RX, B_Q0, K_NOP, 3'd0, 1'b0};
		case (idx)
			5'd0:  m = '{A_RX, B_Q1, K_ACC, 3'd0, 1'b1};
			5'd1:  m = '{A_RY, B_Q2, K_ACC, 3'd0, 1'b1};
			5'd2:  m = '{A_RZ, B_Q3, K_ACC, 3'd0, 1'b1};
			5'd3:  m = '{A_RX, B_Q0, K_ACC, 3'd1, 1'b0};
			5'd4:  m = '{A_RY, B_Q3, K_ACC, 3'd1, 1'b1};
			5'd5:  m = '{A_RZ, B_Q2, K_ACC, 3'd1, 1'b0};
			5'd6:  m = '{A_RX, B_Q3, K_ACC, 3'd2, 1'b0};
			5'd7:  m = '{A_RY, B_Q0, K_ACC, 3'd2, 1'b0};
			5'd8:  m = '{A_RZ, B_Q1, K_ACC, 3'd2, 1'b1};
			5'd9:  m = '{A_RX, B_Q2, K_ACC, 3'd3, 1'b1};
			5'd10: m = '{A_RY, B_Q1, K_ACC, 3'd3, 1'b0};
			5'd11: m = '{A_RZ, B_Q0, K_ACC, 3'd3, 1'b0};
			5'd12: m = '{A_S,  B_DT, K_UPD, 3'd0, 1'b0};
			5'd13: m = '{A_S,  B_DT, K_UPD, 3'd1, 1'b0};
			5'd14: m = '{A_S,  B_DT, K_UPD, 3'd2, 1'b0};
			5'd15: m = '{A_S,  B_DT, K_UPD, 3'd3, 1'b0};
			5'd16: m = '{A_Q2, B_Q3, K_ANG, 3'd0, 1'b0};
			5'd17: m = '{A_Q0, B_Q1, K_ANG, 3'd0, 1'b0};
			5'd18: m = '{A_Q1, B_Q1, K_ANG, 3'd1, 1'b0};
			5'd19: m = '{A_Q2, B_Q2, K_ANG, 3'd1, 1'b0};
			5'd20: m = '{A_Q1, B_Q3, K_ANG, 3'd2, 1'b0};
			5'd21: m = '{A_Q0, B_Q2, K_ANG, 3'd2, 1'b1};
			5'd22: m = '{A_Q1, B_Q2, K_ANG, 3'd3, 1'b0};
			5'd23: m = '{A_Q0, B_Q3, K_ANG, 3'd3, 1'b0};
			5'd24: m = '{A_Q2, B_Q2, K_ANG, 3'd4, 1'b0};
			5'd25: m = '{A_Q3, B_Q3, K_ANG, 3'd4, 1'b0};
			5'd26: m = '{A_SP, B_SP, K_SQ,  3'd0, 1'b0};
			default: m = '{A_RX, B_Q0, K_NOP, 3'd0, 1'b0};
		endcase
		return m;
	endfunction

	// arctan(2^-i) in Q.30
	function automatic logic signed [Z_W-1:0] qap_atan(input logic [CNT_W-1:0] i);
		logic [31:0] v;
		v = 32'h0;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return Z_W'(v);
	endfunction

	// Q.30 angle to Q3.13, round half up, saturate
	function automatic logic signed [ANGLE_W-1:0] qap_angle_out(
		input logic signed [Z_W:0] z);
		logic signed [Z_W:0] t;
		logic signed [ANGLE_W-1:0] r;
		t = (z + (Z_W+1)'(65536)) >>> 17;
		if (t > (Z_W+1)'(32767))
			r = ANGLE_W'(32767);
		else if (t < -(Z_W+1)'(32768))
			r = ANGLE_W'(-32768);
		else
			r = ANGLE_W'(t);
		return r;
	endfunction

	// saturate an updated quaternion part
	function automatic logic signed [QUAT_W-1:0] qap_sat_quat(
		input logic signed [P_W:0] v);
		logic signed [QUAT_W-1:0] r;
		if (v > (P_W+1)'((64'sd1 <<< (QUAT_W-1)) - 1))
			r = {1'b0, {(QUAT_W-1){1'b1}}};
		else if (v < -(P_W+1)'(64'sd1 <<< (QUAT_W-1)))
			r = {1'b1, {(QUAT_W-1){1'b0}}};
		else
			r = QUAT_W'(v);
		return r;
	endfunction

endpackage

>>> hw/rtl/qap_sqrt.sv
// ----------------------------------------------------------------------------
// qap_sqrt: bit-serial integer square root
// Restoring square root, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module qap_sqrt import qap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  radicand,
	output logic             done,
	output logic [QFRAC:0]   root
);

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	// one digit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= SQ_TOP;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[QFRAC:0];

endmodule

>>> hw/rtl/qap_cordic.sv
// ----------------------------------------------------------------------------
// qap_cordic: iterative vectoring CORDIC for atan2
// Inputs are scaled by 256, negative x is pre-rotated by +-pi/2, then one
// micro-rotation per cycle. A zero vector gives an angle of zero.
// ----------------------------------------------------------------------------
module qap_cordic import qap_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ANG_W-1:0]  xin,
	input  logic signed [ANG_W-1:0]  yin,
	output logic                     done,
	output logic signed [Z_W-1:0]    angle
);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        it_q;
	logic signed [X_W-1:0]   x_q;
	logic signed [X_W-1:0]   y_q;
	logic signed [Z_W-1:0]   z_q;
	logic signed [X_W-1:0]   xs;
	logic signed [X_W-1:0]   ys;
	logic signed [X_W-1:0]   xsh;
	logic signed [X_W-1:0]   ysh;
	logic                    zero_vec;
	logic                    last;

	assign xs       = X_W'(xin) <<< 8;
	assign ys       = X_W'(yin) <<< 8;
	assign xsh      = x_q >>> it_q;
	assign ysh      = y_q >>> it_q;
	assign zero_vec = (xin == '0) && (yin == '0);
	assign last     = (it_q == CNT_W'(CORDIC_ITERATIONS - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				it_q   <= '0;
				busy_q <= !zero_vec;
				done_q <= zero_vec;
			end else if (busy_q) begin
				it_q <= it_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// vector and angle registers
	always_ff @(posedge clk) begin
		if (start) begin
			if (zero_vec) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (xs < 0) begin
				if (ys >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= HALF_PI;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -HALF_PI;
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				z_q <= z_q + qap_atan(it_q);
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				z_q <= z_q - qap_atan(it_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

>>> hw/rtl/qap_datapath.sv
// ----------------------------------------------------------------------------
// qap_datapath: quaternion state, shared multiplier and angle units
// One signed multiplier walks the micro-op table: rate products, the four
// step updates, the angle products and the asin cosine term. The square
// root and CORDIC units then finish the angles into the output register.
// ----------------------------------------------------------------------------
module qap_datapath import qap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qap_cmd_t              cmd,
	output qap_sts_t              sts,
	input  qap_in_t               in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qap_out_t              out_data
);

	// configuration
	logic [DT_W-1:0]          dt_q;
	logic signed [RATE_W-1:0] bias_q [3];

	// state and working registers
	logic signed [QUAT_W-1:0] quat_q [4];
	logic signed [BODY_W-1:0] body_q [3];
	logic signed [ACC_W-1:0]  acc_q  [4];
	logic signed [ANG_W-1:0]  ang_q  [5];
	logic signed [P_W-1:0]    prod_q;
	logic [SQ_W-1:0]          rad_q;
	logic signed [ANGLE_W-1:0] roll_q, pitch_q, yaw_q;
	logic                     out_valid_q;
	qap_out_t                 out_q;

	qap_mop_t                 mop;
	logic signed [MA_W-1:0]   ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [P_W:0]      dsum;
	logic signed [P_W:0]      qnew;
	logic signed [ANG_W-1:0]  sp_raw, sp_c;
	logic signed [ANG_W-1:0]  cx, cy;
	logic signed [Z_W-1:0]    crd_angle;
	logic                     crd_done;
	logic                     sq_done;
	logic [QFRAC:0]           sq_root;

	assign mop = qap_mop(cmd.op_idx);

	// clamped asin argument
	assign sp_raw = ang_q[2] <<< 1;
	always_comb begin
		if (sp_raw > ONE_ANG)
			sp_c = ONE_ANG;
		else if (sp_raw < -ONE_ANG)
			sp_c = -ONE_ANG;
		else
			sp_c = sp_raw;
	end

	// multiplier operand select
	always_comb begin
		case (mop.asel)
			A_RX:    ma = MA_W'(body_q[0]);
			A_RY:    ma = MA_W'(body_q[1]);
			A_RZ:    ma = MA_W'(body_q[2]);
			A_Q0:    ma = MA_W'(quat_q[0]);
			A_Q1:    ma = MA_W'(quat_q[1]);
			A_Q2:    ma = MA_W'(quat_q[2]);
			A_Q3:    ma = MA_W'(quat_q[3]);
			A_S:     ma = MA_W'(acc_q[mop.dst[1:0]] >>> 12);
			A_SP:    ma = MA_W'(sp_c);
			default: ma = '0;
		endcase
		case (mop.bsel)
			B_Q0:    mb = MB_W'(quat_q[0]);
			B_Q1:    mb = MB_W'(quat_q[1]);
			B_Q2:    mb = MB_W'(quat_q[2]);
			B_Q3:    mb = MB_W'(quat_q[3]);
			B_DT:    mb = MB_W'({1'b0, dt_q});
			B_SP:    mb = MB_W'(sp_c);
			default: mb = '0;
		endcase
	end

	// step update: round the dt product, add, saturate
	assign dsum = ((P_W+1)'(prod_q) + (P_W+1)'(65536)) >>> 17;
	assign qnew = (P_W+1)'(quat_q[mop.dst[1:0]]) + dsum;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q      <= DT_RESET;
			bias_q[0] <= '0;
			bias_q[1] <= '0;
			bias_q[2] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_PERIOD: dt_q      <= cfg_data;
				CFG_BIAS_X:        bias_q[0] <= cfg_data;
				CFG_BIAS_Y:        bias_q[1] <= cfg_data;
				CFG_BIAS_Z:        bias_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// quaternion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= ONE_QUAT;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else if (cmd.accept && in_data.command) begin
			quat_q[0] <= in_data.load_w;
			quat_q[1] <= in_data.load_x;
			quat_q[2] <= in_data.load_y;
			quat_q[3] <= in_data.load_z;
		end else if (cmd.op_b && mop.kind == K_UPD) begin
			quat_q[mop.dst[1:0]] <= qap_sat_quat(qnew);
		end
	end

	// multiply and accumulate
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			body_q[0] <= BODY_W'(in_data.rate_x) - BODY_W'(bias_q[0]);
			body_q[1] <= BODY_W'(in_data.rate_y) - BODY_W'(bias_q[1]);
			body_q[2] <= BODY_W'(in_data.rate_z) - BODY_W'(bias_q[2]);
			for (int k = 0; k < 4; k++)
				acc_q[k] <= '0;
			for (int k = 0; k < 5; k++)
				ang_q[k] <= '0;
		end
		if (cmd.op_a)
			prod_q <= ma * mb;
		if (cmd.op_b) begin
			case (mop.kind)
				K_ACC: begin
					if (mop.neg)
						acc_q[mop.dst[1:0]] <= acc_q[mop.dst[1:0]] - ACC_W'(prod_q);
					else
						acc_q[mop.dst[1:0]] <= acc_q[mop.dst[1:0]] + ACC_W'(prod_q);
				end
				K_ANG: begin
					if (mop.neg)
						ang_q[mop.dst] <= ang_q[mop.dst] - ANG_W'(prod_q >>> QFRAC);
					else
						ang_q[mop.dst] <= ang_q[mop.dst] + ANG_W'(prod_q >>> QFRAC);
				end
				K_SQ:    rad_q <= SQ_TOP - SQ_W'(prod_q);
				default: ;
			endcase
		end
	end

	qap_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_go),
		.radicand (rad_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// CORDIC input per angle
	always_comb begin
		case (cmd.ang_sel)
			ANG_ROLL: begin
				cy = ang_q[0] <<< 1;
				cx = ONE_ANG - (ang_q[1] <<< 1);
			end
			ANG_PITCH: begin
				cy = sp_c;
				cx = ANG_W'({1'b0, sq_root});
			end
			ANG_YAW: begin
				cy = ang_q[3] <<< 1;
				cx = ONE_ANG - (ang_q[4] <<< 1);
			end
			default: begin
				cy = '0;
				cx = '0;
			end
		endcase
	end

	qap_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cordic_go),
		.xin    (cx),
		.yin    (cy),
		.done   (crd_done),
		.angle  (crd_angle)
	);

	// angle capture
	always_ff @(posedge clk) begin
		if (crd_done) begin
			case (cmd.ang_sel)
				ANG_ROLL:  roll_q  <= qap_angle_out((Z_W+1)'(crd_angle));
				ANG_PITCH: pitch_q <= qap_angle_out(-(Z_W+1)'(crd_angle));
				ANG_YAW:   yaw_q   <= qap_angle_out((Z_W+1)'(crd_angle));
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.publish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.publish)
			out_q <= '{quat_q[0], quat_q[1], quat_q[2], quat_q[3],
				roll_q, pitch_q, yaw_q};
	end

	assign sts.sqrt_done   = sq_done;
	assign sts.cordic_done = crd_done;
	assign sts.out_free    = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

>>> hw/rtl/qap_ctrl.sv
// ----------------------------------------------------------------------------
// qap_ctrl: sequencer for the attitude propagator
// Steps the multiplier micro-ops, then the square root, then three CORDIC
// runs, and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module qap_ctrl import qap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_load,
	output logic     in_ready,
	input  qap_sts_t sts,
	output qap_cmd_t cmd
);

	qap_state_t      state_q, state_d;
	logic [OP_W-1:0] idx_q, idx_d;
	qap_ang_t        sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			sel_q   <= ANG_ROLL;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sel_q   <= sel_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		sel_d         = sel_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.op_idx    = idx_q;
		cmd.ang_sel   = sel_q;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					idx_d   = in_load ? OP_ANG_FIRST : '0;
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.op_a = 1'b1;
				state_d  = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.op_b = 1'b1;
				if (idx_q == OP_LAST) begin
					state_d = ST_SQRT_GO;
				end else begin
					idx_d   = idx_q + OP_W'(1);
					state_d = ST_MUL_A;
				end
			end
			ST_SQRT_GO: begin
				cmd.sqrt_go = 1'b1;
				state_d     = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (sts.sqrt_done) begin
					sel_d   = ANG_ROLL;
					state_d = ST_CRD_GO;
				end
			end
			ST_CRD_GO: begin
				cmd.cordic_go = 1'b1;
				state_d       = ST_CRD_WAIT;
			end
			ST_CRD_WAIT: begin
				if (sts.cordic_done) begin
					if (sel_q == ANG_YAW) begin
						state_d = ST_FINISH;
					end else begin
						sel_d   = qap_ang_t'(sel_q + 2'd1);
						state_d = ST_CRD_GO;
					end
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/quaternion_attitude_propagator.sv
// ----------------------------------------------------------------------------
// quaternion_attitude_propagator: first-order quaternion step with angles
//
//   channel | dir | handshake             | word
//   in      | in  | in_valid / in_ready   | qap_in_t  (command, rates, load)
//   out     | out | out_valid / out_ready | qap_out_t (quaternion, angles)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word at a time. From acceptance to publish a word passes through an
// accept step, MUL_A and MUL_B for each product on the single shared
// multiplier (27 products for a propagate word, 11 for a load), the start
// and run of the square root, three CORDIC runs, and the publish.
// Reset sets the quaternion to identity, dt to 66 and the biases to zero.
// The output register frees the input side: a new word is taken while the
// last result still waits; only a second finished result waits on out_ready.
// ----------------------------------------------------------------------------
module quaternion_attitude_propagator import qap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qap_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qap_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	qap_cmd_t cmd;
	qap_sts_t sts;

	assign cfg_ready = 1'b1;

	qap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_load  (in_data.command),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qap_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a taken word keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// a publish always leaves a valid result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("published result not presented");

	// square root and CORDIC never finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.sqrt_done && sts.cordic_done))
		else $error("angle units finished together");

	// a publish never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || out_ready))
		else $error("result overwritten");

endmodule
